FILE: rtl/dsp_pkg.sv
package dsp_pkg;

  localparam int W  = 32;
  localparam int FB = 16;
  localparam int EW = W + 4;

  typedef logic signed [W-1:0]  word_t;
  typedef logic signed [EW-1:0] wide_t;
  typedef logic [W-2:0]         time_t;
  typedef logic [2:0]           seg_t;
  typedef logic [2:0]           reg_idx_t;

  localparam word_t WMAX = {1'b0, {(W-1){1'b1}}};
  localparam word_t WMIN = {1'b1, {(W-1){1'b0}}};
  localparam word_t ONE  = {{(W-FB-1){1'b0}}, 1'b1, {FB{1'b0}}};
  localparam word_t ZERO = '0;

  // unsigned divide by six: (n * magic) >> shift, exact for any 32 bit n
  localparam logic [W-1:0] RECIP6    = 32'hAAAA_AAAB;
  localparam int           RECIP6_SH = 34;

  // profile segments in time order
  localparam seg_t SEG_ACC_RISE = 3'd0;
  localparam seg_t SEG_ACC_FLAT = 3'd1;
  localparam seg_t SEG_ACC_FALL = 3'd2;
  localparam seg_t SEG_CRUISE   = 3'd3;
  localparam seg_t SEG_DEC_RISE = 3'd4;
  localparam seg_t SEG_DEC_FLAT = 3'd5;
  localparam seg_t SEG_DEC_END  = 3'd6;

  // configuration register indexes
  localparam reg_idx_t REG_ACCEL_TIME      = 3'd0;
  localparam reg_idx_t REG_CRUISE_TIME     = 3'd1;
  localparam reg_idx_t REG_DECEL_TIME      = 3'd2;
  localparam reg_idx_t REG_ACCEL_JERK_TIME = 3'd3;
  localparam reg_idx_t REG_DECEL_JERK_TIME = 3'd4;
  localparam reg_idx_t REG_START_VELOCITY  = 3'd5;
  localparam reg_idx_t REG_ACCEL_JERK      = 3'd6;
  localparam reg_idx_t REG_DECEL_JERK      = 3'd7;

  typedef struct packed {
    time_t ta;
    time_t tv;
    time_t td;
    time_t tj1;
    time_t tj2;
    word_t v0;
    word_t j1;
    word_t j2;
  } dsp_cfg_t;

  typedef struct packed {
    word_t v0;
    word_t j1;
    word_t j2;
    word_t tj1;
    word_t tj2;
    word_t a1;
    word_t a2;
    word_t vl;
    word_t v1;
    word_t qae;
    word_t qa;
    word_t base;
    wide_t b0;
    wide_t b1;
    wide_t b2;
    wide_t b3;
    wide_t b4;
    wide_t b5;
    wide_t tsum;
  } dsp_prof_t;

  typedef struct packed {
    seg_t  seg;
    word_t x;
  } dsp_item_t;

  typedef enum logic [3:0] {
    DS_IDLE, DS_S0, DS_S1, DS_S2, DS_S3, DS_S4, DS_S5,
    DS_S6, DS_S7, DS_S8, DS_S9, DS_S10, DS_S11
  } dsp_step_t;

  function automatic word_t sat_w(input wide_t v);
    if (v > wide_t'(WMAX)) return WMAX;
    if (v < wide_t'(WMIN)) return WMIN;
    return word_t'(v);
  endfunction

  function automatic word_t sadd(input word_t a, input word_t b);
    wide_t s;
    s = wide_t'(a) + wide_t'(b);
    return sat_w(s);
  endfunction

  function automatic word_t ssub(input word_t a, input word_t b);
    wide_t s;
    s = wide_t'(a) - wide_t'(b);
    return sat_w(s);
  endfunction

  function automatic word_t half(input word_t a);
    wide_t s;
    s = wide_t'(a) + wide_t'(a[W-1]);
    return word_t'(s >>> 1);
  endfunction

  function automatic word_t mul3(input word_t a);
    wide_t s;
    s = (wide_t'(a) <<< 1) + wide_t'(a);
    return sat_w(s);
  endfunction

  // fixed point product, magnitude truncated, saturated
  function automatic word_t smul(input word_t a, input word_t b);
    logic signed [2*W-1:0] p;
    logic [2*W-1:0]        m;
    logic [2*W-1:0]        lim;
    logic                  neg;
    p   = a * b;
    neg = p[2*W-1];
    m   = neg ? (~$unsigned(p) + 1'b1) : $unsigned(p);
    m   = m >> FB;
    lim = neg ? {{W{1'b0}}, 1'b1, {(W-1){1'b0}}} : {{(W+1){1'b0}}, {(W-1){1'b1}}};
    if (m > lim) m = lim;
    return neg ? word_t'(~m[W-1:0] + 1'b1) : word_t'(m[W-1:0]);
  endfunction

endpackage

FILE: rtl/dsp_derive.sv
module dsp_derive import dsp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      restart,
  input  dsp_cfg_t  cfg,
  output dsp_prof_t prof,
  output logic      busy
);

  word_t     ta, tv, td, tj1, tj2;
  dsp_step_t st_r, st_nxt;
  word_t     mul_a, mul_b;
  word_t     p_r, d1_r, d2_r, sv0_r, svv_r, m1_r, m2_r, q1_r, q_r;
  dsp_prof_t prof_r;

  assign ta  = word_t'({1'b0, cfg.ta});
  assign tv  = word_t'({1'b0, cfg.tv});
  assign td  = word_t'({1'b0, cfg.td});
  assign tj1 = word_t'({1'b0, cfg.tj1});
  assign tj2 = word_t'({1'b0, cfg.tj2});

  always_comb begin
    if (restart) begin
      st_nxt = DS_S0;
    end else begin
      case (st_r)
        DS_S0:   st_nxt = DS_S1;
        DS_S1:   st_nxt = DS_S2;
        DS_S2:   st_nxt = DS_S3;
        DS_S3:   st_nxt = DS_S4;
        DS_S4:   st_nxt = DS_S5;
        DS_S5:   st_nxt = DS_S6;
        DS_S6:   st_nxt = DS_S7;
        DS_S7:   st_nxt = DS_S8;
        DS_S8:   st_nxt = DS_S9;
        DS_S9:   st_nxt = DS_S10;
        DS_S10:  st_nxt = DS_S11;
        default: st_nxt = DS_IDLE;
      endcase
    end
  end

  // shared multiplier operands
  always_comb begin
    mul_a = ZERO;
    mul_b = ZERO;
    case (st_r)
      DS_S0: begin
        mul_a = cfg.j1;
        mul_b = tj1;
      end
      DS_S1: begin
        mul_a = cfg.j2;
        mul_b = tj2;
      end
      DS_S2: begin
        mul_a = prof_r.a1;
        mul_b = d1_r;
      end
      DS_S3: begin
        mul_a = prof_r.a2;
        mul_b = d2_r;
      end
      DS_S5: begin
        mul_a = sv0_r;
        mul_b = half(ta);
      end
      DS_S6: begin
        mul_a = prof_r.vl;
        mul_b = tv;
      end
      DS_S7: begin
        mul_a = svv_r;
        mul_b = half(td);
      end
      default: begin
        mul_a = ZERO;
        mul_b = ZERO;
      end
    endcase
  end

  assign busy = (st_r != DS_IDLE);
  assign prof = prof_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= DS_S0;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r <= smul(mul_a, mul_b);
    case (st_r)
      DS_S0: begin
        d1_r        <= ssub(ta, tj1);
        d2_r        <= ssub(td, tj2);
        prof_r.v0   <= cfg.v0;
        prof_r.j1   <= cfg.j1;
        prof_r.j2   <= cfg.j2;
        prof_r.tj1  <= tj1;
        prof_r.tj2  <= tj2;
        prof_r.b0   <= wide_t'(tj1);
        prof_r.b1   <= wide_t'(ta) - wide_t'(tj1);
        prof_r.b2   <= wide_t'(ta);
        prof_r.b3   <= wide_t'(ta) + wide_t'(tv);
        prof_r.tsum <= wide_t'(ta) + wide_t'(tv) + wide_t'(td);
      end
      DS_S1: begin
        prof_r.a1 <= p_r;
        prof_r.b4 <= prof_r.b3 + wide_t'(tj2);
        prof_r.b5 <= prof_r.tsum - wide_t'(tj2);
      end
      DS_S2: prof_r.a2 <= p_r;
      DS_S3: prof_r.vl <= sadd(prof_r.v0, p_r);
      DS_S4: begin
        prof_r.v1 <= sadd(prof_r.vl, p_r);
        sv0_r     <= sadd(prof_r.vl, prof_r.v0);
      end
      DS_S5: svv_r      <= sadd(prof_r.vl, prof_r.v1);
      DS_S6: prof_r.qae <= p_r;
      DS_S7: m1_r       <= p_r;
      DS_S8: begin
        m2_r <= p_r;
        q1_r <= sadd(prof_r.qae, m1_r);
      end
      DS_S9:  q_r         <= sadd(q1_r, m2_r);
      DS_S10: prof_r.qa   <= q_r[W-1] ? ssub(ZERO, q_r) : q_r;
      DS_S11: prof_r.base <= ssub(prof_r.qa, m2_r);
      default: ;
    endcase
  end

endmodule

FILE: rtl/dsp_front.sv
module dsp_front import dsp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      take,
  input  time_t     t,
  input  dsp_prof_t prof,
  input  logic      q_full,
  output logic      ready,
  output logic      push,
  output dsp_item_t item
);

  wide_t     tw;
  dsp_item_t cls;
  logic      vld_r;
  dsp_item_t item_r;

  assign tw = wide_t'({1'b0, t});

  // segment search in time order, first boundary above the time wins
  always_comb begin
    if (tw < prof.b0) begin
      cls.seg = SEG_ACC_RISE;
      cls.x   = sat_w(tw);
    end else if (tw < prof.b1) begin
      cls.seg = SEG_ACC_FLAT;
      cls.x   = sat_w(tw);
    end else if (tw < prof.b2) begin
      cls.seg = SEG_ACC_FALL;
      cls.x   = sat_w(prof.b2 - tw);
    end else if (tw < prof.b3) begin
      cls.seg = SEG_CRUISE;
      cls.x   = sat_w(tw - prof.b2);
    end else if (tw < prof.b4) begin
      cls.seg = SEG_DEC_RISE;
      cls.x   = sat_w(tw - prof.b3);
    end else if (tw < prof.b5) begin
      cls.seg = SEG_DEC_FLAT;
      cls.x   = sat_w(tw - prof.b3);
    end else begin
      cls.seg = SEG_DEC_END;
      cls.x   = sat_w(prof.tsum - tw);
    end
  end

  assign ready = !vld_r || !q_full;
  assign push  = vld_r && !q_full;
  assign item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (take) begin
      vld_r <= 1'b1;
    end else if (push) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= cls;
    end
  end

endmodule

FILE: rtl/dsp_queue.sv
module dsp_queue import dsp_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  dsp_item_t din,
  input  logic      pop,
  output dsp_item_t dout,
  output logic      empty,
  output logic      full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  dsp_item_t       mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   cnt_r;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == CW'(DEPTH));
  assign dout  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

FILE: rtl/dsp_back.sv
module dsp_back import dsp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  dsp_item_t item,
  input  dsp_prof_t prof,
  output logic      out_valid,
  output word_t     pos,
  output word_t     vel,
  output word_t     acc,
  output seg_t      seg
);

  // per segment operand selection
  word_t m_sel, c_sel, k_sel, tj_sel, vb_sel, vk_sel, ak_sel, ax_sel;
  logic  psub, pflat, vflat, vsub;

  always_comb begin
    m_sel  = prof.v0;
    c_sel  = ZERO;
    psub   = 1'b0;
    k_sel  = prof.j1;
    pflat  = 1'b0;
    tj_sel = prof.tj1;
    vb_sel = prof.v0;
    vk_sel = prof.j1;
    vflat  = 1'b0;
    vsub   = 1'b0;
    ak_sel = prof.j1;
    ax_sel = item.x;
    case (item.seg)
      SEG_ACC_RISE: ;
      SEG_ACC_FLAT: begin
        k_sel  = prof.a1;
        pflat  = 1'b1;
        vk_sel = prof.a1;
        vflat  = 1'b1;
        ak_sel = prof.a1;
        ax_sel = ONE;
      end
      SEG_ACC_FALL: begin
        m_sel  = prof.vl;
        c_sel  = prof.qae;
        psub   = 1'b1;
        vb_sel = prof.vl;
        vsub   = 1'b1;
      end
      SEG_CRUISE: begin
        m_sel  = prof.vl;
        c_sel  = prof.qae;
        k_sel  = ZERO;
        vb_sel = prof.vl;
        vk_sel = ZERO;
        ak_sel = ZERO;
      end
      SEG_DEC_RISE: begin
        m_sel  = prof.vl;
        c_sel  = prof.base;
        k_sel  = prof.j2;
        tj_sel = prof.tj2;
        vb_sel = prof.vl;
        vk_sel = prof.j2;
        ak_sel = prof.j2;
      end
      SEG_DEC_FLAT: begin
        m_sel  = prof.vl;
        c_sel  = prof.base;
        k_sel  = prof.a2;
        pflat  = 1'b1;
        tj_sel = prof.tj2;
        vb_sel = prof.vl;
        vk_sel = prof.a2;
        vflat  = 1'b1;
        ak_sel = prof.a2;
        ax_sel = ONE;
      end
      default: begin
        m_sel  = prof.v1;
        c_sel  = prof.qa;
        psub   = 1'b1;
        k_sel  = prof.j2;
        tj_sel = prof.tj2;
        vb_sel = prof.v1;
        vk_sel = prof.j2;
        vsub   = 1'b1;
        ak_sel = prof.j2;
      end
    endcase
  end

  logic [4:0] vld_r;

  // stage a: first products
  word_t a_xx_r, a_mx_r, a_tjx_r, a_tjtj_r, a_acc_r, a_x_r, a_tj_r, a_c_r;
  word_t a_k_r, a_vb_r, a_vk_r;
  logic  a_psub_r, a_pflat_r, a_vflat_r, a_vsub_r;
  seg_t  a_seg_r;

  always_ff @(posedge clk) begin
    a_xx_r    <= smul(item.x, item.x);
    a_mx_r    <= smul(m_sel, item.x);
    a_tjx_r   <= smul(tj_sel, item.x);
    a_tjtj_r  <= smul(tj_sel, tj_sel);
    a_acc_r   <= smul(ak_sel, ax_sel);
    a_x_r     <= item.x;
    a_tj_r    <= tj_sel;
    a_c_r     <= c_sel;
    a_k_r     <= k_sel;
    a_vb_r    <= vb_sel;
    a_vk_r    <= vk_sel;
    a_psub_r  <= psub;
    a_pflat_r <= pflat;
    a_vflat_r <= vflat;
    a_vsub_r  <= vsub;
    a_seg_r   <= item.seg;
  end

  // stage b: cube, flat polynomial, base position, velocity factor
  word_t b_cube_r, b_flat_r, b_p0_r, b_va_r, b_k_r, b_vk_r, b_vb_r, b_acc_r;
  logic  b_pflat_r, b_vsub_r;
  seg_t  b_seg_r;

  always_ff @(posedge clk) begin
    b_cube_r  <= smul(a_xx_r, a_x_r);
    b_flat_r  <= sadd(ssub(mul3(a_xx_r), mul3(a_tjx_r)), a_tjtj_r);
    b_p0_r    <= a_psub_r ? ssub(a_c_r, a_mx_r) : sadd(a_c_r, a_mx_r);
    b_va_r    <= a_vflat_r ? ssub(a_x_r, half(a_tj_r)) : half(a_xx_r);
    b_k_r     <= a_k_r;
    b_vk_r    <= a_vk_r;
    b_vb_r    <= a_vb_r;
    b_acc_r   <= a_acc_r;
    b_pflat_r <= a_pflat_r;
    b_vsub_r  <= a_vsub_r;
    b_seg_r   <= a_seg_r;
  end

  // stage c: jerk and velocity products
  word_t c_kp_r, c_vp_r, c_p0_r, c_vb_r, c_acc_r;
  logic  c_vsub_r;
  seg_t  c_seg_r;

  always_ff @(posedge clk) begin
    c_kp_r   <= smul(b_k_r, b_pflat_r ? b_flat_r : b_cube_r);
    c_vp_r   <= smul(b_vk_r, b_va_r);
    c_p0_r   <= b_p0_r;
    c_vb_r   <= b_vb_r;
    c_vsub_r <= b_vsub_r;
    c_acc_r  <= b_acc_r;
    c_seg_r  <= b_seg_r;
  end

  // stage d: divide by six through reciprocal, velocity sum
  logic [W-1:0]   kmag;
  logic [2*W-1:0] kprod;
  logic [W-1:0]   d_q6_r;
  logic           d_kneg_r;
  word_t          d_p0_r, d_vel_r, d_acc_r;
  seg_t           d_seg_r;

  assign kmag  = c_kp_r[W-1] ? (~$unsigned(c_kp_r) + 1'b1) : $unsigned(c_kp_r);
  assign kprod = {{W{1'b0}}, kmag} * {{W{1'b0}}, RECIP6};

  always_ff @(posedge clk) begin
    d_q6_r   <= W'(kprod >> RECIP6_SH);
    d_kneg_r <= c_kp_r[W-1];
    d_p0_r   <= c_p0_r;
    d_vel_r  <= c_vsub_r ? ssub(c_vb_r, c_vp_r) : sadd(c_vb_r, c_vp_r);
    d_acc_r  <= c_acc_r;
    d_seg_r  <= c_seg_r;
  end

  // stage e: final position sum
  word_t d6;
  word_t e_pos_r, e_vel_r, e_acc_r;
  seg_t  e_seg_r;

  assign d6 = d_kneg_r ? word_t'(~d_q6_r + 1'b1) : word_t'(d_q6_r);

  always_ff @(posedge clk) begin
    e_pos_r <= sadd(d_p0_r, d6);
    e_vel_r <= d_vel_r;
    e_acc_r <= d_acc_r;
    e_seg_r <= d_seg_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[3:0], in_valid};
    end
  end

  assign out_valid = vld_r[4];
  assign pos       = e_pos_r;
  assign vel       = e_vel_r;
  assign acc       = e_acc_r;
  assign seg       = e_seg_r;

endmodule

FILE: rtl/double_s_profile_evaluator.sv
// seven segment jerk limited motion profile, evaluated at one sample time
//
// configuration: cfg_valid/cfg_ready write channel, cfg_index picks one of the
// eight profile registers, cfg_data carries the value; cfg_ready is always high.
// each write restarts a derivation of peak accelerations, peak and
// end velocity and displacement on one shared multiplier; busy is high for it.
// reset clears all registers and runs the same derivation, so busy is high after
// reset until that derivation completes.
//
// command: a sample time is taken with start high and busy low. a front stage
// classifies the time into its segment, a short queue decouples it from a five
// stage polynomial pipeline that yields position, speed, acceleration, segment.
// a transfer reaches out_valid through the front register, queue and pipeline;
// a new time is taken every cycle unless busy holds it off (pipelined back end).
// results show for exactly one cycle on out_valid; the receiver cannot stall,
// so the queue drains every cycle and busy reflects the derivation or a full queue
module double_s_profile_evaluator import dsp_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [30:0] in_sample_time,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        out_valid,
  output logic [31:0] out_position,
  output logic [31:0] out_speed,
  output logic [31:0] out_accel,
  output logic [2:0]  out_segment
);

  dsp_cfg_t  cfg_r;
  dsp_prof_t prof;
  logic      cfg_xfer, in_xfer;
  logic      derive_busy, front_ready, push, q_full, q_empty;
  dsp_item_t front_item, q_item;
  word_t     pos, vel, acc;
  seg_t      seg;

  assign cfg_ready = 1'b1;
  assign cfg_xfer  = cfg_valid && cfg_ready;
  assign busy      = derive_busy || !front_ready;
  assign in_xfer   = start && !busy;

  // register file, time registers keep their low 31 bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_xfer) begin
      case (cfg_index)
        REG_ACCEL_TIME:      cfg_r.ta  <= cfg_data[W-2:0];
        REG_CRUISE_TIME:     cfg_r.tv  <= cfg_data[W-2:0];
        REG_DECEL_TIME:      cfg_r.td  <= cfg_data[W-2:0];
        REG_ACCEL_JERK_TIME: cfg_r.tj1 <= cfg_data[W-2:0];
        REG_DECEL_JERK_TIME: cfg_r.tj2 <= cfg_data[W-2:0];
        REG_START_VELOCITY:  cfg_r.v0  <= cfg_data;
        REG_ACCEL_JERK:      cfg_r.j1  <= cfg_data;
        REG_DECEL_JERK:      cfg_r.j2  <= cfg_data;
        default: ;
      endcase
    end
  end

  // derived profile values, recomputed after every register transfer
  dsp_derive u_derive (
    .clk     (clk),
    .rst_n   (rst_n),
    .restart (cfg_xfer),
    .cfg     (cfg_r),
    .prof    (prof),
    .busy    (derive_busy)
  );

  // segment classification and local time
  dsp_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .take   (in_xfer),
    .t      (in_sample_time),
    .prof   (prof),
    .q_full (q_full),
    .ready  (front_ready),
    .push   (push),
    .item   (front_item)
  );

  dsp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (front_item),
    .pop   (!q_empty),
    .dout  (q_item),
    .empty (q_empty),
    .full  (q_full)
  );

  // polynomial pipeline, drains the queue every cycle
  dsp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (!q_empty),
    .item      (q_item),
    .prof      (prof),
    .out_valid (out_valid),
    .pos       (pos),
    .vel       (vel),
    .acc       (acc),
    .seg       (seg)
  );

  assign out_position = pos;
  assign out_speed    = vel;
  assign out_accel    = acc;
  assign out_segment  = seg;

  // a register transfer always holds off the command side next cycle
  a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_xfer |=> busy) else $error("busy low after register transfer");

  // every result stems from a command transfer through the front register, queue and pipeline
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_xfer, 7)) else $error("result without matching transfer");

  a_segment: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_segment <= SEG_DEC_END)) else $error("segment out of range");

endmodule

FILE: tb/tb_double_s_profile_evaluator.sv
`timescale 1ns / 100ps

module tb_double_s_profile_evaluator;

  // one evaluated sample of the profile
  typedef struct {
    logic [31:0] position;
    logic [31:0] speed;
    logic [31:0] accel;
    logic [2:0]  segment;
  } profile_sample_t;

  localparam longint WORD_MAX = 64'sd2147483647;
  localparam longint WORD_MIN = -64'sd2147483648;
  localparam int     Q_ONE    = 65536;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [30:0] in_sample_time;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        out_valid;
  logic [31:0] out_position;
  logic [31:0] out_speed;
  logic [31:0] out_accel;
  logic [2:0]  out_segment;

  // predictor copy of the profile registers
  logic [31:0] profile_regs [8];

  profile_sample_t expected_samples[$];
  int              error_count;
  int              sender_idle_pct;

  double_s_profile_evaluator u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_sample_time (in_sample_time),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_position   (out_position),
    .out_speed      (out_speed),
    .out_accel      (out_accel),
    .out_segment    (out_segment)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // ---------------------------------------------------------------------------
  // fixed point helpers, all operands kept inside the 32 bit word range
  // ---------------------------------------------------------------------------
  function automatic longint clamp_word(longint x);
    if (x > WORD_MAX) return WORD_MAX;
    if (x < WORD_MIN) return WORD_MIN;
    return x;
  endfunction

  function automatic longint q_add(longint a, longint b);
    return clamp_word(a + b);
  endfunction

  function automatic longint q_sub(longint a, longint b);
    return clamp_word(a - b);
  endfunction

  // product magnitude truncated toward zero, then saturated
  function automatic longint q_mul(longint a, longint b);
    longint p;
    longint mag;
    longint lim;
    bit     neg;
    p   = a * b;
    neg = (p < 0);
    mag = neg ? -p : p;
    mag = mag >> 16;
    lim = neg ? (WORD_MAX + 1) : WORD_MAX;
    if (mag > lim) mag = lim;
    return neg ? -mag : mag;
  endfunction

  function automatic longint q_cube(longint x);
    return q_mul(q_mul(x, x), x);
  endfunction

  // 3x^2 - 3*tj*x + tj^2 of the constant acceleration segments
  function automatic longint q_flat(longint x, longint tj);
    longint s;
    s = q_sub(clamp_word(q_mul(x, x) * 3), clamp_word(q_mul(tj, x) * 3));
    return q_add(s, q_mul(tj, tj));
  endfunction

  function automatic logic [31:0] to_word(longint x);
    return x[31:0];
  endfunction

  // position, speed, acceleration and segment at one sample time
  function automatic profile_sample_t eval_profile(logic [30:0] sample);
    profile_sample_t r;
    longint ta, tv, td, tj1, tj2, v0, j1, j2, t;
    longint a1, vl, a2, v1, q, qa, q_acc_end, base, x;
    longint pos, vel, acc;
    ta  = longint'({33'd0, profile_regs[0][30:0]});
    tv  = longint'({33'd0, profile_regs[1][30:0]});
    td  = longint'({33'd0, profile_regs[2][30:0]});
    tj1 = longint'({33'd0, profile_regs[3][30:0]});
    tj2 = longint'({33'd0, profile_regs[4][30:0]});
    v0  = longint'($signed(profile_regs[5]));
    j1  = longint'($signed(profile_regs[6]));
    j2  = longint'($signed(profile_regs[7]));
    t   = longint'({33'd0, sample});

    // derived peak values and displacement
    a1        = q_mul(j1, tj1);
    vl        = q_add(v0, q_mul(a1, q_sub(ta, tj1)));
    a2        = q_mul(j2, tj2);
    v1        = q_add(vl, q_mul(a2, q_sub(td, tj2)));
    q_acc_end = q_mul(q_add(vl, v0), ta / 2);
    q         = q_add(q_add(q_acc_end, q_mul(vl, tv)), q_mul(q_add(vl, v1), td / 2));
    qa        = (q < 0) ? clamp_word(-q) : q;
    base      = q_sub(qa, q_mul(q_add(vl, v1), td / 2));

    // boundaries compared exactly, first one above the time wins
    if (t < tj1) begin
      r.segment = dsp_pkg::SEG_ACC_RISE;
      pos = q_add(q_mul(v0, t), q_mul(j1, q_cube(t)) / 6);
      vel = q_add(v0, q_mul(j1, q_mul(t, t) / 2));
      acc = q_mul(j1, t);
    end else if (t < ta - tj1) begin
      r.segment = dsp_pkg::SEG_ACC_FLAT;
      pos = q_add(q_mul(v0, t), q_mul(a1, q_flat(t, tj1)) / 6);
      vel = q_add(v0, q_mul(a1, q_sub(t, tj1 / 2)));
      acc = a1;
    end else if (t < ta) begin
      r.segment = dsp_pkg::SEG_ACC_FALL;
      x   = clamp_word(ta - t);
      pos = q_add(q_sub(q_acc_end, q_mul(vl, x)), q_mul(j1, q_cube(x)) / 6);
      vel = q_sub(vl, q_mul(j1, q_mul(x, x) / 2));
      acc = q_mul(j1, x);
    end else if (t < ta + tv) begin
      r.segment = dsp_pkg::SEG_CRUISE;
      pos = q_add(q_acc_end, q_mul(vl, clamp_word(t - ta)));
      vel = vl;
      acc = 0;
    end else if (t < ta + tv + tj2) begin
      r.segment = dsp_pkg::SEG_DEC_RISE;
      x   = clamp_word(t - ta - tv);
      pos = q_add(q_add(base, q_mul(vl, x)), q_mul(j2, q_cube(x)) / 6);
      vel = q_add(vl, q_mul(j2, q_mul(x, x) / 2));
      acc = q_mul(j2, x);
    end else if (t < ta + tv + td - tj2) begin
      r.segment = dsp_pkg::SEG_DEC_FLAT;
      x   = clamp_word(t - ta - tv);
      pos = q_add(q_add(base, q_mul(vl, x)), q_mul(a2, q_flat(x, tj2)) / 6);
      vel = q_add(vl, q_mul(a2, q_sub(x, tj2 / 2)));
      acc = a2;
    end else begin
      // final cubic, extrapolated past the end
      r.segment = dsp_pkg::SEG_DEC_END;
      x   = clamp_word(ta + tv + td - t);
      pos = q_add(q_sub(qa, q_mul(v1, x)), q_mul(j2, q_cube(x)) / 6);
      vel = q_sub(v1, q_mul(j2, q_mul(x, x) / 2));
      acc = q_mul(j2, x);
    end
    r.position = to_word(pos);
    r.speed    = to_word(vel);
    r.accel    = to_word(acc);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // transfer monitor and result checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      expected_samples.insert(expected_samples.size(), eval_profile(in_sample_time));
    end
  end

  always @(posedge clk) begin
    profile_sample_t exp_s;
    if (rst_n && out_valid) begin
      if (expected_samples.size() == 0) begin
        $error("unexpected result: position %h segment %0d", out_position, out_segment);
        error_count++;
      end else begin
        exp_s = expected_samples.pop_front();
        if (out_position !== exp_s.position) begin
          $error("position: expected %h actual %h", exp_s.position, out_position);
          error_count++;
        end
        if (out_speed !== exp_s.speed) begin
          $error("speed: expected %h actual %h", exp_s.speed, out_speed);
          error_count++;
        end
        if (out_accel !== exp_s.accel) begin
          $error("accel: expected %h actual %h", exp_s.accel, out_accel);
          error_count++;
        end
        if (out_segment !== exp_s.segment) begin
          $error("segment: expected %0d actual %0d", exp_s.segment, out_segment);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus tasks
  // ---------------------------------------------------------------------------

  // one sample time transfer, with random idle cycles ahead of it
  task automatic send_sample(logic [30:0] t);
    while ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start          <= 1'b1;
    in_sample_time <= t;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
  endtask

  // drop start and let every outstanding result arrive
  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_profile_reg(logic [2:0] idx, logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    profile_regs[idx] = (idx < dsp_pkg::REG_START_VELOCITY) ? {1'b0, value[30:0]} : value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_profile(logic [31:0] ta, logic [31:0] tv, logic [31:0] td,
                              logic [31:0] tj1, logic [31:0] tj2, logic [31:0] v0,
                              logic [31:0] j1, logic [31:0] j2);
    drain_results();
    write_profile_reg(dsp_pkg::REG_ACCEL_TIME, ta);
    write_profile_reg(dsp_pkg::REG_CRUISE_TIME, tv);
    write_profile_reg(dsp_pkg::REG_DECEL_TIME, td);
    write_profile_reg(dsp_pkg::REG_ACCEL_JERK_TIME, tj1);
    write_profile_reg(dsp_pkg::REG_DECEL_JERK_TIME, tj2);
    write_profile_reg(dsp_pkg::REG_START_VELOCITY, v0);
    write_profile_reg(dsp_pkg::REG_ACCEL_JERK, j1);
    write_profile_reg(dsp_pkg::REG_DECEL_JERK, j2);
  endtask

  // all registers cleared: every time lands in the final segment
  task automatic test_reset_profile();
    sender_idle_pct = 0;
    send_sample(31'd0);
    send_sample(31'h7FFF_FFFF);
    send_sample(31'd65536);
  endtask

  // a well formed profile, sampled on and just below every boundary
  task automatic test_segment_boundaries();
    logic [30:0] edges [6];
    load_profile(2 * Q_ONE, Q_ONE, 2 * Q_ONE, Q_ONE / 2, Q_ONE / 2,
                 32'd0, 2 * Q_ONE, -2 * Q_ONE);
    edges = '{31'd32768, 31'd98304, 31'd131072, 31'd196608, 31'd229376, 31'd294912};
    foreach (edges[i]) begin
      send_sample(edges[i] - 31'd1);
      send_sample(edges[i]);
    end
    send_sample(31'd0);
    send_sample(31'd327680);   // at the total time
    send_sample(31'h7FFF_FFFF);
  endtask

  // saturating and inconsistent corners
  task automatic test_extreme_profiles();
    // everything at its largest
    load_profile(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_sample(31'd0);
    send_sample(31'h4000_0000);
    send_sample(31'h7FFF_FFFF);
    // most negative velocity and jerks, giving a negative displacement
    load_profile(Q_ONE, Q_ONE, Q_ONE, Q_ONE / 4, Q_ONE / 4,
                 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_sample(31'd1000);
    send_sample(31'd100000);
    send_sample(31'd250000);
    // jerk ramp longer than the phase: segments overlap and get skipped
    load_profile(Q_ONE, 32'd0, Q_ONE / 2, 3 * Q_ONE, 2 * Q_ONE,
                 -Q_ONE, Q_ONE, Q_ONE);
    send_sample(31'd40000);
    send_sample(31'd70000);
    send_sample(31'd200000);
  endtask

  function automatic logic [31:0] pick_time_reg(int span);
    case ($urandom_range(9))
      0:       return 32'd0;
      1:       return 32'h7FFF_FFFF;
      2:       return $urandom;
      default: return $urandom_range(span);
    endcase
  endfunction

  function automatic logic [31:0] pick_signed_reg(int span);
    case ($urandom_range(9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return $urandom;
      default: return $urandom_range(2 * span) - span;
    endcase
  endfunction

  // random profiles, mostly well formed, with random sample times over them
  task automatic test_random_profiles(int idle_pct, int n_profiles, int per_profile);
    logic [31:0] ta, tv, td, tj1, tj2;
    int          span;
    sender_idle_pct = idle_pct;
    repeat (n_profiles) begin
      if ($urandom_range(3) != 0) begin
        tj1 = $urandom_range(2 * Q_ONE);
        ta  = 2 * tj1 + $urandom_range(2 * Q_ONE);
        tv  = $urandom_range(4 * Q_ONE);
        tj2 = $urandom_range(2 * Q_ONE);
        td  = 2 * tj2 + $urandom_range(2 * Q_ONE);
        load_profile(ta, tv, td, tj1, tj2, $urandom_range(8 * Q_ONE) - 4 * Q_ONE,
                     $urandom_range(8 * Q_ONE), -$urandom_range(8 * Q_ONE));
      end else begin
        load_profile(pick_time_reg(8 * Q_ONE), pick_time_reg(8 * Q_ONE),
                     pick_time_reg(8 * Q_ONE), pick_time_reg(2 * Q_ONE),
                     pick_time_reg(2 * Q_ONE), pick_signed_reg(16 * Q_ONE),
                     pick_signed_reg(16 * Q_ONE), pick_signed_reg(16 * Q_ONE));
      end
      span = profile_regs[0][30:0] + profile_regs[1][30:0] + profile_regs[2][30:0];
      if (span <= 0 || span > 32'h3FFF_FFFF) span = 32'h3FFF_FFFF;
      repeat (per_profile) begin
        if ($urandom_range(7) == 0) send_sample(31'($urandom));
        else send_sample(31'($urandom_range(span + span / 4)));
      end
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    start          = 1'b0;
    in_sample_time = '0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    error_count    = 0;
    sender_idle_pct = 0;
    foreach (profile_regs[i]) profile_regs[i] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_profile();
    test_segment_boundaries();
    test_extreme_profiles();
    test_random_profiles(0, 10, 30);
    test_random_profiles(76, 10, 30);
    test_random_profiles(0, 8, 30);
    test_random_profiles(28, 10, 30);

    drain_results();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/dsp_pkg.sv
rtl/dsp_derive.sv
rtl/dsp_front.sv
rtl/dsp_queue.sv
rtl/dsp_back.sv
rtl/double_s_profile_evaluator.sv
tb/tb_double_s_profile_evaluator.sv
